### rtl/core/mbps_pkg.sv
`default_nettype none

package mbps_pkg;

	// Fixed sizes of the scanner
	localparam int MAX_PATTERN  = 16;
	localparam int ADDRESS_BITS = 48;
	localparam int BYTE_W       = 8;
	localparam int CFG_DATA_W   = 64;
	localparam int CFG_INDEX_W  = 3;
	localparam int MASK_W       = 16;
	localparam int LEN_W        = 5;
	localparam int CNT_W        = $clog2(MAX_PATTERN + 1);
	localparam int PAT_W        = MAX_PATTERN * BYTE_W;

	// Register indexes of the configuration port
	localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_COMPARE_MASK   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_ONLY     = 3'd4;

	// Reset values of the registers
	localparam logic [MASK_W-1:0] COMPARE_MASK_RST   = 16'hFFFF;
	localparam logic [LEN_W-1:0]  PATTERN_LENGTH_RST = 5'd1;

	// One scanned byte
	typedef struct packed {
		logic [BYTE_W-1:0]       data_byte;
		logic [ADDRESS_BITS-1:0] byte_address;
		logic                    region_first;
		logic                    new_scan;
	} scan_req_t;

	// One scan result
	typedef struct packed {
		logic                    match_found;
		logic [ADDRESS_BITS-1:0] match_address;
	} scan_res_t;

endpackage

`default_nettype wire

### rtl/core/masked_byte_pattern_scanner.sv
// A result is registered and presented in the cycle after its request is accepted.
// Throughput: one request per cycle while in_ready is high; the window compare is a single registered pass.
// in_ready drops only while a result waits and out_ready is low.
// Reset (arst_n low, asynchronous): window, fill count, first-match latch and output
// valid clear; registers return to pattern 0, mask all ones, length 1, all-match mode.
`default_nettype none

module masked_byte_pattern_scanner (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// configuration write port
	input  wire logic                                   cfg_write,
	input  wire logic [mbps_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  wire logic [mbps_pkg::CFG_DATA_W-1:0]        cfg_data,
	// request channel
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire mbps_pkg::scan_req_t                    in_req,
	// result channel
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output mbps_pkg::scan_res_t                         out_res
);

	localparam int NB = mbps_pkg::MAX_PATTERN;
	localparam int BW = mbps_pkg::BYTE_W;

	// configuration registers
	logic [mbps_pkg::PAT_W-1:0]  pattern_q;
	logic [mbps_pkg::MASK_W-1:0] mask_q;
	logic [mbps_pkg::LEN_W-1:0]  length_q;
	logic                        first_only_q;

	// scan state
	logic [BW-1:0]               window_q [NB];
	logic [mbps_pkg::CNT_W-1:0]  fill_q;
	logic                        latch_q;

	// output register
	logic                        out_valid_q;
	mbps_pkg::scan_res_t         out_q;

	// next-state and compare signals
	logic                        accept;
	logic [BW-1:0]               window_d [NB];
	logic [mbps_pkg::CNT_W-1:0]  fill_d;
	logic                        latch_cur;
	logic                        latch_d;
	logic [mbps_pkg::LEN_W-1:0]  len_eff;
	logic [mbps_pkg::LEN_W-1:0]  shift_amt;
	logic [mbps_pkg::PAT_W-1:0]  pat_rev;
	logic [mbps_pkg::PAT_W-1:0]  pat_align;
	logic [NB-1:0]               mask_rev;
	logic [NB-1:0]               mask_align;
	logic [NB-1:0]               pos_ok;
	logic                        match_raw;
	logic                        match_rep;
	logic [mbps_pkg::ADDRESS_BITS-1:0] start_addr;
	mbps_pkg::scan_res_t         res_d;

	assign accept    = in_valid && in_ready;
	assign in_ready  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q    <= '0;
			mask_q       <= mbps_pkg::COMPARE_MASK_RST;
			length_q     <= mbps_pkg::PATTERN_LENGTH_RST;
			first_only_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				mbps_pkg::CFG_PATTERN_LOW:    pattern_q[mbps_pkg::CFG_DATA_W-1:0] <= cfg_data;
				mbps_pkg::CFG_PATTERN_HIGH:   pattern_q[mbps_pkg::PAT_W-1:mbps_pkg::CFG_DATA_W]
					<= cfg_data;
				mbps_pkg::CFG_COMPARE_MASK:   mask_q <= cfg_data[mbps_pkg::MASK_W-1:0];
				mbps_pkg::CFG_PATTERN_LENGTH: length_q <= cfg_data[mbps_pkg::LEN_W-1:0];
				mbps_pkg::CFG_FIRST_ONLY:     first_only_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// window shift, region start clears older bytes
	always_comb begin
		window_d[0] = in_req.data_byte;
		for (int i = 1; i < NB; i++) begin
			window_d[i] = in_req.region_first ? '0 : window_q[i-1];
		end
	end

	// saturating fill count of the current region
	always_comb begin
		if (in_req.region_first) begin
			fill_d = mbps_pkg::CNT_W'(1);
		end else if (fill_q < mbps_pkg::CNT_W'(NB)) begin
			fill_d = fill_q + mbps_pkg::CNT_W'(1);
		end else begin
			fill_d = fill_q;
		end
	end

	// length clamp; window slot k lines up with pattern byte len-1-k
	assign len_eff   = (length_q > mbps_pkg::LEN_W'(NB)) ? mbps_pkg::LEN_W'(NB) : length_q;
	assign shift_amt = mbps_pkg::LEN_W'(NB) - len_eff;

	always_comb begin
		for (int i = 0; i < NB; i++) begin
			pat_rev[i*BW +: BW] = pattern_q[(NB-1-i)*BW +: BW];
			mask_rev[i]         = mask_q[NB-1-i];
		end
	end

	// slots at or beyond the length shift in zero mask bits
	assign pat_align  = pat_rev >> (BW * shift_amt);
	assign mask_align = mask_rev >> shift_amt;

	// per-slot compare, wildcard slots always pass
	always_comb begin
		for (int k = 0; k < NB; k++) begin
			pos_ok[k] = !mask_align[k] || (window_d[k] == pat_align[k*BW +: BW]);
		end
	end

	assign match_raw = (length_q != '0) && (fill_d >= mbps_pkg::CNT_W'(len_eff)) && (&pos_ok);

	// first-match latch
	assign latch_cur = in_req.new_scan ? 1'b0 : latch_q;
	assign match_rep = match_raw && !(first_only_q && latch_cur);
	assign latch_d   = latch_cur || (match_raw && first_only_q);

	// start address of the match
	assign start_addr = in_req.byte_address
		- mbps_pkg::ADDRESS_BITS'(len_eff - mbps_pkg::LEN_W'(1));

	always_comb begin
		res_d.match_found   = match_rep;
		res_d.match_address = match_rep ? start_addr : '0;
	end

	// scan state update on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NB; i++) begin
				window_q[i] <= '0;
			end
			fill_q  <= '0;
			latch_q <= 1'b0;
		end else if (accept) begin
			for (int i = 0; i < NB; i++) begin
				window_q[i] <= window_d[i];
			end
			fill_q  <= fill_d;
			latch_q <= latch_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= res_d;
		end
	end

endmodule

`default_nettype wire
